[src/irbt_pkg.sv]
`default_nettype none
package irbt_pkg;
    localparam int NUM_CANDIDATES = 16;
    localparam int NUM_WINNERS    = 4;
    localparam int CIDX_W = $clog2(NUM_CANDIDATES);
    localparam int SIDX_W = (NUM_WINNERS > 1) ? $clog2(NUM_WINNERS) : 1;
    localparam int COORD_W = 10;
    localparam int SCORE_W = 8;
    localparam int DIST_W  = 11;
    localparam int ENTRY_W = COORD_W + COORD_W + SCORE_W;
    localparam logic [COORD_W-1:0] PARK      = 10'd1023;
    localparam logic [COORD_W-1:0] CENTRE    = 10'd512;
    localparam logic [SCORE_W-1:0] REWARD    = 8'd5;
    localparam logic [SCORE_W-1:0] REWARD_LIMIT = 8'd250;
    localparam logic [DIST_W-1:0]  THRESH_RESET = 11'd64;

    typedef enum logic [1:0] {
        KIND_BLOB   = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_REPORT = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCAN_END, ST_UPDATE,
        ST_FRAME, ST_SORT_LOAD, ST_SORT, ST_PICK, ST_EMIT_RD, ST_EMIT
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SCORE_W-1:0] score;
    } entry_t;
endpackage
`default_nettype wire

[src/irbt_ram.sv]
`default_nettype none
module irbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/ir_blob_tracker.sv]
`default_nettype none
// Channel   | Direction | Payload
// s_axis    | in        | tdata: kind(2) x_low(8) y_low(8) high_size(8)
// m_axis    | out       | tdata: slot candidate_index point_x point_y score; tlast
// cfg       | in        | distance threshold (11 bits)
//
// A blob walks the candidate memory once for the distance and minimum search
// and then writes back before the next transaction is taken. A frame end is a
// read-modify-write sweep. An ignored blob or an unknown kind returns straight
// to idle. A report copies the 16 scores, runs an insertion sort over the rank
// table at one compare step per cycle, refills the slots and then reads each
// result from the candidate memory before it is sent. After reset a clearing
// pass fills the candidate memory; no transaction is taken until it ends. A
// stalled result simply holds the block.
module ir_blob_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // kind [1:0], byte_x_low [9:2], byte_y_low [17:10], byte_high_size [25:18]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // slot [1:0], candidate_index [5:2], point_x [15:6], point_y [25:16], score [33:26]
    output logic [39:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    localparam int CW = irbt_pkg::CIDX_W;
    localparam int SW = irbt_pkg::SIDX_W;
    localparam int NC = irbt_pkg::NUM_CANDIDATES;
    localparam int NW = irbt_pkg::NUM_WINNERS;

    irbt_pkg::state_t state_reg, state_next;
    logic [irbt_pkg::DIST_W-1:0] thr_reg;

    // Candidate memory.
    logic          we;
    logic [CW-1:0] waddr, raddr;
    irbt_pkg::entry_t wdata, rdata;
    irbt_ram #(.WIDTH(irbt_pkg::ENTRY_W), .DEPTH(NC)) u_cand (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Rank order and per-rank score copy, small register arrays for the sort.
    logic [CW-1:0] rank_reg [NC];
    logic [irbt_pkg::SCORE_W-1:0] rsc_reg [NC];
    logic [CW-1:0] ws_reg [NW];
    logic [NW-1:0] wv_reg;

    logic [CW:0] cnt_reg;
    logic [CW:0] j_reg;
    logic [CW-1:0] rd_reg;      // address of data arriving this cycle
    logic          rdv_reg;
    logic [irbt_pkg::COORD_W-1:0] bx_reg, by_reg;
    logic [13:0]   best_reg;
    logic [CW-1:0] near_reg, worst_reg;
    logic [8:0]    low_reg;
    logic [SW:0] emit_reg;
    logic [39:0] mdata_reg;
    logic mvalid_reg, mlast_reg;

    logic [irbt_pkg::COORD_W-1:0] in_x, in_y, dx, dy;
    logic [13:0] mdist;
    assign in_x = {s_axis_tdata[23:22], s_axis_tdata[9:2]};
    assign in_y = {s_axis_tdata[25:24], s_axis_tdata[17:10]};
    assign dx = (bx_reg > rdata.x) ? bx_reg - rdata.x : rdata.x - bx_reg;
    assign dy = (by_reg > rdata.y) ? by_reg - rdata.y : rdata.y - by_reg;
    assign mdist = 14'(dx) + 14'(dy);

    function automatic logic [irbt_pkg::SCORE_W-1:0] rsc_score(input logic [CW-1:0] c);
        logic [irbt_pkg::SCORE_W-1:0] r;
        r = '0;
        for (int k = 0; k < NC; k++) begin
            if (rank_reg[k] == c) r = rsc_reg[k];
        end
        return r;
    endfunction

    // Slot pick for rank cnt_reg: held check and lowest key.
    logic held;
    logic [SW-1:0] pick;
    logic [8:0] key, lowkey;
    always_comb begin
        held = 1'b0;
        pick = '0;
        lowkey = 9'd256;
        key = '0;
        for (int s = 0; s < NW; s++) begin
            if (wv_reg[s] && ws_reg[s] == rank_reg[cnt_reg[CW-1:0]]) held = 1'b1;
        end
        for (int s = 0; s < NW; s++) begin
            key = wv_reg[s] ? 9'(rsc_score(ws_reg[s])) + 9'd1 : 9'd0;
            if (key < lowkey) begin
                lowkey = key;
                pick = SW'(s);
            end
        end
    end

    logic [CW-1:0] jm, jm1;
    assign jm  = j_reg[CW-1:0];
    assign jm1 = CW'(j_reg - 1'b1);

    assign s_axis_tready = (state_reg == irbt_pkg::ST_IDLE) && !mvalid_reg;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tlast  = mlast_reg;

    always_comb begin
        state_next = state_reg;
        we = 1'b0;
        waddr = rd_reg;
        wdata = rdata;
        raddr = cnt_reg[CW-1:0];
        unique case (state_reg)
            irbt_pkg::ST_CLEAR: begin
                we = 1'b1;
                waddr = cnt_reg[CW-1:0];
                wdata = '{x: irbt_pkg::CENTRE, y: irbt_pkg::CENTRE, score: '0};
                if (cnt_reg == (CW+1)'(NC - 1)) state_next = irbt_pkg::ST_IDLE;
            end
            irbt_pkg::ST_IDLE: begin
                raddr = '0;
                if (s_axis_tvalid && s_axis_tready) begin
                    unique case (irbt_pkg::kind_t'(s_axis_tdata[1:0]))
                        irbt_pkg::KIND_BLOB:
                            if (in_y != irbt_pkg::PARK) state_next = irbt_pkg::ST_SCAN;
                        irbt_pkg::KIND_FRAME:  state_next = irbt_pkg::ST_FRAME;
                        irbt_pkg::KIND_REPORT: state_next = irbt_pkg::ST_SORT_LOAD;
                        default: state_next = irbt_pkg::ST_IDLE;
                    endcase
                end
            end
            irbt_pkg::ST_SCAN: begin
                if (cnt_reg == (CW+1)'(NC)) state_next = irbt_pkg::ST_SCAN_END;
            end
            irbt_pkg::ST_SCAN_END: begin
                raddr = near_reg;
                state_next = irbt_pkg::ST_UPDATE;
            end
            irbt_pkg::ST_UPDATE: begin
                we = 1'b1;
                if (best_reg <= 14'(thr_reg)) begin
                    waddr = near_reg;
                    wdata.x = bx_reg;
                    wdata.y = by_reg;
                    wdata.score = (rdata.score < irbt_pkg::REWARD_LIMIT) ?
                                  rdata.score + irbt_pkg::REWARD : rdata.score;
                end else begin
                    waddr = worst_reg;
                    wdata = '{x: bx_reg, y: by_reg, score: irbt_pkg::REWARD};
                end
                state_next = irbt_pkg::ST_IDLE;
            end
            irbt_pkg::ST_FRAME: begin
                if (rdv_reg) begin
                    we = 1'b1;
                    if (rdata.score != '0) wdata.score = rdata.score - 1'b1;
                    else begin
                        wdata.x = irbt_pkg::PARK;
                        wdata.y = irbt_pkg::PARK;
                    end
                end
                if (cnt_reg == (CW+1)'(NC)) state_next = irbt_pkg::ST_IDLE;
            end
            irbt_pkg::ST_SORT_LOAD: begin
                if (cnt_reg == (CW+1)'(NC)) state_next = irbt_pkg::ST_SORT;
            end
            irbt_pkg::ST_SORT: begin
                if (cnt_reg == (CW+1)'(NC)) state_next = irbt_pkg::ST_PICK;
            end
            irbt_pkg::ST_PICK: begin
                if (cnt_reg == (CW+1)'(NW) || cnt_reg == (CW+1)'(NC))
                    state_next = irbt_pkg::ST_EMIT_RD;
            end
            irbt_pkg::ST_EMIT_RD: begin
                raddr = ws_reg[emit_reg[SW-1:0]];
                state_next = irbt_pkg::ST_EMIT;
            end
            irbt_pkg::ST_EMIT: begin
                raddr = ws_reg[emit_reg[SW-1:0]];
                if (!mvalid_reg || m_axis_tready) begin
                    if (emit_reg == (SW+1)'(NW - 1)) state_next = irbt_pkg::ST_IDLE;
                    else state_next = irbt_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = irbt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= irbt_pkg::ST_CLEAR;
            thr_reg <= irbt_pkg::THRESH_RESET;
            cnt_reg <= '0;
            rdv_reg <= 1'b0;
            wv_reg <= '0;
            mvalid_reg <= 1'b0;
            for (int k = 0; k < NC; k++) begin
                rank_reg[k] <= CW'(k);
                rsc_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) thr_reg <= cfg_wdata;
            // In the emit state the valid flag is set again below.
            if (mvalid_reg && m_axis_tready && state_reg != irbt_pkg::ST_EMIT)
                mvalid_reg <= 1'b0;
            rd_reg <= raddr;
            unique case (state_reg)
                irbt_pkg::ST_CLEAR: cnt_reg <= cnt_reg + 1'b1;
                irbt_pkg::ST_IDLE: begin
                    bx_reg <= in_x;
                    by_reg <= in_y;
                    best_reg <= 14'd10000;
                    low_reg <= 9'd255;
                    near_reg <= '0;
                    worst_reg <= '0;
                    cnt_reg <= (CW+1)'(1);
                    rdv_reg <= 1'b1;
                    j_reg <= '0;
                    emit_reg <= '0;
                end
                irbt_pkg::ST_SCAN: begin
                    if (rdv_reg) begin
                        if (mdist < best_reg) begin
                            best_reg <= mdist;
                            near_reg <= rd_reg;
                        end
                        if (9'(rdata.score) < low_reg) begin
                            low_reg <= 9'(rdata.score);
                            worst_reg <= rd_reg;
                        end
                    end
                    rdv_reg <= (cnt_reg < (CW+1)'(NC));
                    if (cnt_reg < (CW+1)'(NC)) cnt_reg <= cnt_reg + 1'b1;
                end
                irbt_pkg::ST_FRAME: begin
                    rdv_reg <= (cnt_reg < (CW+1)'(NC));
                    if (cnt_reg < (CW+1)'(NC)) cnt_reg <= cnt_reg + 1'b1;
                end
                irbt_pkg::ST_SORT_LOAD: begin
                    // Copy each candidate's score next to its rank entry.
                    if (rdv_reg) begin
                        for (int k = 0; k < NC; k++) begin
                            if (rank_reg[k] == rd_reg) rsc_reg[k] <= rdata.score;
                        end
                    end
                    rdv_reg <= (cnt_reg < (CW+1)'(NC));
                    if (cnt_reg < (CW+1)'(NC)) cnt_reg <= cnt_reg + 1'b1;
                    else begin
                        cnt_reg <= (CW+1)'(1);
                        j_reg <= (CW+1)'(1);
                    end
                end
                irbt_pkg::ST_SORT: begin
                    // One compare-and-swap step of insertion sort per cycle.
                    if (cnt_reg != (CW+1)'(NC)) begin
                        if (j_reg != '0 && rsc_reg[jm1] < rsc_reg[jm]) begin
                            rank_reg[jm1] <= rank_reg[jm];
                            rank_reg[jm]  <= rank_reg[jm1];
                            rsc_reg[jm1]  <= rsc_reg[jm];
                            rsc_reg[jm]   <= rsc_reg[jm1];
                            j_reg <= j_reg - 1'b1;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                            j_reg <= cnt_reg + 1'b1;
                        end
                    end else cnt_reg <= '0;
                end
                irbt_pkg::ST_PICK: begin
                    if (cnt_reg != (CW+1)'(NW) && cnt_reg != (CW+1)'(NC)) begin
                        if (!held) begin
                            ws_reg[pick] <= rank_reg[cnt_reg[CW-1:0]];
                            wv_reg[pick] <= 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                irbt_pkg::ST_EMIT: begin
                    if (!mvalid_reg || m_axis_tready) begin
                        mvalid_reg <= 1'b1;
                        mlast_reg <= (emit_reg == (SW+1)'(NW - 1));
                        mdata_reg[1:0] <= 2'(emit_reg);
                        if (wv_reg[emit_reg[SW-1:0]]) begin
                            mdata_reg[5:2]   <= 4'(ws_reg[emit_reg[SW-1:0]]);
                            mdata_reg[15:6]  <= rdata.x;
                            mdata_reg[25:16] <= rdata.y;
                            mdata_reg[33:26] <= rdata.score;
                        end else begin
                            mdata_reg[5:2]   <= '0;
                            mdata_reg[15:6]  <= irbt_pkg::PARK;
                            mdata_reg[25:16] <= irbt_pkg::PARK;
                            mdata_reg[33:26] <= '0;
                        end
                        mdata_reg[39:34] <= '0;
                        emit_reg <= emit_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
